// File: src/anp_pkg.sv
// Shared constants, character codes and types of the ASCII number parser.
package anp_pkg;

	// Depth of each of the two small queues (a power of two)
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	// Character codes
	localparam logic [7:0] CH_BS       = 8'h08;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;
	localparam logic [7:0] CH_A        = 8'h41;
	localparam logic [7:0] CH_F        = 8'h46;
	localparam logic [7:0] CH_X        = 8'h58;
	localparam logic [7:0] CH_LOW_A    = 8'h61;
	localparam logic [7:0] CH_LOW_Z    = 8'h7A;
	localparam logic [7:0] CH_DEL      = 8'h7F;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	// Terminator value that means no terminator is set
	localparam logic [7:0] NO_TERM = 8'h00;

	// Offset from the low nibble of 'A'..'F' to the digit value
	localparam logic [3:0] HEX_LETTER_OFFSET = 4'd9;

	// Divide by ten: quotient = (n * RECIP10) >> RECIP_SHIFT for any 32-bit n
	localparam logic [31:0] RECIP10     = 32'hCCCCCCCD;
	localparam int          RECIP_SHIFT = 35;
	localparam logic [31:0] DEC_BASE    = 32'd10;
	localparam logic [31:0] HEX_BASE    = 32'd16;

	// Character class as seen in the collecting phase
	typedef enum logic [2:0] {
		CLS_END    = 3'd0,
		CLS_DEC    = 3'd1,
		CLS_HEX    = 3'd2,
		CLS_IGNORE = 3'd3,
		CLS_ERASE  = 3'd4,
		CLS_BAD    = 3'd5
	} cls_t;

	// Classified character handed from front to back
	typedef struct packed {
		logic       skip;     // '0' or space: dropped while skipping
		logic       sel_hex;  // 'X': selects hex while skipping
		cls_t       cls;
		logic       top;      // terminator match, sets bit 31
		logic [3:0] digit;
	} cmd_t;

	// One result item
	typedef struct packed {
		logic        done_res;
		logic [31:0] number;
		logic        bad_char;
		logic        erase;
	} res_t;

endpackage

// File: src/anp_front.sv
// Front end: terminator register, case folding and character classification.
module anp_front import anp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic [7:0] char_in,
	output cmd_t       cmd
);

	logic [7:0] term_q;
	logic [7:0] folded;
	logic       term_hit;

	// Hold the terminator character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q <= NO_TERM;
		end else if (cfg_we) begin
			term_q <= cfg_wdata;
		end
	end

	// Fold lower case to upper case
	always_comb begin
		folded = char_in;
		if (char_in >= CH_LOW_A && char_in <= CH_LOW_Z) begin
			folded = char_in - CASE_OFFSET;
		end
	end

	assign term_hit = (folded == term_q);

	// Classify; ending characters take precedence over digits
	always_comb begin
		cmd.skip    = (folded == CH_ZERO) || (folded == CH_SPACE);
		cmd.sel_hex = (folded == CH_X);
		cmd.top     = term_hit && (term_q != NO_TERM);
		cmd.digit   = folded[3:0];
		if (term_hit || folded == CH_CR) begin
			cmd.cls = CLS_END;
		end else if (folded >= CH_ZERO && folded <= CH_NINE) begin
			cmd.cls = CLS_DEC;
		end else if (folded >= CH_A && folded <= CH_F) begin
			cmd.cls   = CLS_HEX;
			cmd.digit = folded[3:0] + HEX_LETTER_OFFSET;
		end else if (folded == CH_LF || folded == CH_SPACE) begin
			cmd.cls = CLS_IGNORE;
		end else if (folded == CH_BS || folded == CH_DEL) begin
			cmd.cls = CLS_ERASE;
		end else begin
			cmd.cls = CLS_BAD;
		end
	end

endmodule

// File: src/anp_cmd_queue.sv
// Short queue of classified characters between front and back.
module anp_cmd_queue import anp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	output logic full,
	input  logic pop,
	output cmd_t rdata,
	output logic empty
);

	cmd_t           mem_q [QDEPTH];
	logic [QAW-1:0] wptr_q;
	logic [QAW-1:0] rptr_q;
	logic [QCW-1:0] count_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (count_q == QCW'(QDEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	// Store an entry on each accepted transfer
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// Advance pointers and track fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + QAW'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + QAW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

endmodule

// File: src/anp_back.sv
// Back end: number state, accumulation, erase and the result queue.
module anp_back import anp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  logic cmd_empty,
	output logic cmd_pop,
	input  logic res_pop,
	output res_t res,
	output logic res_empty
);

	logic           phase_q;
	logic           hex_q;
	logic [31:0]    acc_q;

	res_t           rq_q [QDEPTH];
	logic [QAW-1:0] wptr_q;
	logic [QAW-1:0] rptr_q;
	logic [QCW-1:0] count_q;
	logic           res_full;
	logic           do_res_pop;

	logic           phase_d;
	logic           hex_d;
	logic [31:0]    acc_d;
	res_t           res_d;
	logic [63:0]    prod;
	logic [31:0]    quot10;
	logic           below_base;

	assign res_full   = (count_q == QCW'(QDEPTH));
	assign res_empty  = (count_q == '0);
	assign do_res_pop = res_pop && !res_empty;
	assign cmd_pop    = !cmd_empty && !res_full;
	assign res        = rq_q[rptr_q];

	// Divide by ten through the reciprocal
	assign prod       = 64'(acc_q) * 64'(RECIP10);
	assign quot10     = 32'(prod >> RECIP_SHIFT);
	assign below_base = hex_q ? (acc_q < HEX_BASE) : (acc_q < DEC_BASE);

	// Work out the next state and the result of one character
	always_comb begin
		phase_d = phase_q;
		hex_d   = hex_q;
		acc_d   = acc_q;
		res_d   = '0;
		if (!phase_q && cmd.skip) begin
			phase_d = 1'b0;
		end else if (!phase_q && cmd.sel_hex) begin
			phase_d = 1'b1;
			hex_d   = 1'b1;
		end else begin
			phase_d = 1'b1;
			case (cmd.cls)
				CLS_END: begin
					res_d.done_res = 1'b1;
					res_d.number   = acc_q | {cmd.top, 31'd0};
					phase_d        = 1'b0;
					hex_d          = 1'b0;
					acc_d          = '0;
				end
				CLS_DEC: begin
					if (hex_q) begin
						acc_d = {acc_q[27:0], 4'd0} + 32'(cmd.digit);
					end else begin
						acc_d = {acc_q[28:0], 3'd0} + {acc_q[30:0], 1'b0}
							+ 32'(cmd.digit);
					end
				end
				CLS_HEX: begin
					if (hex_q) begin
						acc_d = {acc_q[27:0], 4'd0} + 32'(cmd.digit);
					end else begin
						res_d.bad_char = 1'b1;
					end
				end
				CLS_IGNORE: begin
					acc_d = acc_q;
				end
				CLS_ERASE: begin
					res_d.erase = 1'b1;
					acc_d       = hex_q ? {4'd0, acc_q[31:4]} : quot10;
					if (below_base) begin
						res_d.done_res = 1'b1;
						phase_d        = 1'b0;
						hex_d          = 1'b0;
						acc_d          = '0;
					end
				end
				default: begin
					res_d.bad_char = 1'b1;
				end
			endcase
		end
	end

	// Update the number state on each character taken from the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			hex_q   <= 1'b0;
			acc_q   <= '0;
		end else if (cmd_pop) begin
			phase_q <= phase_d;
			hex_q   <= hex_d;
			acc_q   <= acc_d;
		end
	end

	// Store each result
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			rq_q[wptr_q] <= res_d;
		end
	end

	// Advance result queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd_pop) begin
				wptr_q <= wptr_q + QAW'(1);
			end
			if (do_res_pop) begin
				rptr_q <= rptr_q + QAW'(1);
			end
			if (cmd_pop && !do_res_pop) begin
				count_q <= count_q + QCW'(1);
			end else if (do_res_pop && !cmd_pop) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

endmodule

// File: src/ascii_number_parser.sv
// Top level of the ASCII decimal/hex number parser.
//
// Input side is a queue: drive char_in with push high; the character is
// transferred at a clock edge where push is high and full is low.
// Result side is a queue too: while empty is low the oldest result sits on
// done_res, number, bad_char and erase; it is transferred at an edge where
// pop is high. Every character yields exactly one result.
// The user must write the terminator register through cfg_we / cfg_wdata
// only while idle; the block itself does not enforce this.
// Throughput: one character per cycle while the result queue is not full;
// the accumulator update (shift-add for digits, reciprocal multiply for a
// decimal erase) is combinational and registered as each character is taken.
// A four-entry character queue decouples the classifier from the number
// state, and a four-entry result queue follows it. If the receiver stops
// popping, the result queue fills, the back end stops taking characters,
// and full rises once the character queue has filled as well; nothing is
// dropped. Reset clears both queues, the terminator (to none), the phase,
// hex mode and the accumulator.
module ascii_number_parser import anp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        push,
	input  logic [7:0]  char_in,
	output logic        full,
	input  logic        pop,
	output logic        empty,
	output logic        done_res,
	output logic [31:0] number,
	output logic        bad_char,
	output logic        erase
);

	cmd_t front_cmd;
	cmd_t queue_cmd;
	logic cmd_empty;
	logic cmd_pop;
	res_t res;

	// Classify characters
	anp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.char_in   (char_in),
		.cmd       (front_cmd)
	);

	// Decouple classifier from number state
	anp_cmd_queue u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_cmd),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (queue_cmd),
		.empty  (cmd_empty)
	);

	// Update the number and queue results
	anp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (queue_cmd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_pop   (pop),
		.res       (res),
		.res_empty (empty)
	);

	assign done_res = res.done_res;
	assign number   = res.number;
	assign bad_char = res.bad_char;
	assign erase    = res.erase;

	// A bad character never completes a number or erases
	a_bad_alone: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && bad_char |-> !done_res && !erase)
		else $error("bad character result also flags done or erase");

	// Only a completed number carries a value
	a_number_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !done_res |-> number == 32'd0)
		else $error("nonzero number without done");

	// An erase that completes always reports zero
	a_erase_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && erase && done_res |-> number == 32'd0)
		else $error("erase completion with nonzero number");

	// A transfer in with an empty character queue reaches the back end next cycle
	a_cmd_arrives: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full && cmd_empty |=> !cmd_empty)
		else $error("accepted character lost before back end");

endmodule

// File: dv/anp_checker.sv
// Checker of the ASCII number parser: predicts each result and compares transfers.
module anp_checker import anp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        push,
	input  logic [7:0]  char_in,
	input  logic        full,
	input  logic        pop,
	input  logic        empty,
	input  logic        done_res,
	input  logic [31:0] number,
	input  logic        bad_char,
	input  logic        erase,
	output int          fail_count,
	output int          outstanding,
	output int          results_checked,
	output int          numbers_done
);

	// Predicted parser state
	logic [7:0]  term_char;
	logic        collecting;
	logic        hex_sel;
	logic [31:0] accum;

	// Results predicted but not yet popped, oldest first
	res_t parsed_q[$];

	initial begin
		fail_count      = 0;
		outstanding     = 0;
		results_checked = 0;
		numbers_done    = 0;
	end

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s: got %0h, want %0h", $time, what, got, want);
		fail_count++;
	endtask

	// Return to the skipping phase with an empty value
	function automatic void restart_number();
		collecting = 1'b0;
		hex_sel    = 1'b0;
		accum      = '0;
	endfunction

	// Advance the predicted state by one character and return its result
	function automatic res_t parse_char(input logic [7:0] raw);
		res_t        r;
		logic [7:0]  c;
		logic [31:0] base;
		r = '0;
		c = raw;
		if (c >= CH_LOW_A && c <= CH_LOW_Z)
			c = c - CASE_OFFSET;

		// Drop leading zeros and spaces; a first X picks hex
		if (!collecting) begin
			if (c == CH_ZERO || c == CH_SPACE)
				return r;
			collecting = 1'b1;
			if (c == CH_X) begin
				hex_sel = 1'b1;
				return r;
			end
		end

		base = hex_sel ? HEX_BASE : DEC_BASE;
		if (c == term_char || c == CH_CR) begin
			r.done_res = 1'b1;
			r.number   = accum;
			if (c == term_char && term_char != NO_TERM)
				r.number[31] = 1'b1;
			restart_number();
		end else if (c >= CH_ZERO && c <= CH_NINE) begin
			accum = accum * base + 32'(c - CH_ZERO);
		end else if (hex_sel && c >= CH_A && c <= CH_F) begin
			accum = accum * HEX_BASE + 32'(c[3:0]) + 32'(HEX_LETTER_OFFSET);
		end else if (c == CH_LF || c == CH_SPACE) begin
			// ignore
		end else if (c == CH_BS || c == CH_DEL) begin
			accum   = accum / base;
			r.erase = 1'b1;
			// erasing the last digit ends the number at zero
			if (accum == '0) begin
				r.done_res = 1'b1;
				r.number   = '0;
				restart_number();
			end
		end else begin
			r.bad_char = 1'b1;
		end
		return r;
	endfunction

	// Compare popped results, then queue the prediction for a pushed character
	always @(posedge clk or negedge arst_n) begin : watch_channels
		res_t got;
		res_t want;
		if (!arst_n) begin
			term_char = NO_TERM;
			restart_number();
			parsed_q.delete();
			outstanding <= 0;
		end else begin
			if (pop && !empty) begin
				got = '{done_res, number, bad_char, erase};
				if (parsed_q.size() == 0) begin
					flag_mismatch("result with nothing expected", got.number, '0);
				end else begin
					want = parsed_q.pop_front();
					if (got.done_res !== want.done_res)
						flag_mismatch("done_res", got.done_res, want.done_res);
					if (got.number !== want.number)
						flag_mismatch("number", got.number, want.number);
					if (got.bad_char !== want.bad_char)
						flag_mismatch("bad_char", got.bad_char, want.bad_char);
					if (got.erase !== want.erase)
						flag_mismatch("erase", got.erase, want.erase);
					results_checked++;
					if (want.done_res)
						numbers_done++;
				end
			end
			if (push && !full)
				parsed_q.push_back(parse_char(char_in));
			if (cfg_we)
				term_char = cfg_wdata;
			outstanding <= parsed_q.size();
		end
	end

endmodule

// File: dv/tb_ascii_number_parser.sv
// Testbench top of the ASCII number parser: stimulus, idling and verdict.
module tb_ascii_number_parser import anp_pkg::*;;

	localparam int PHASE_CHARS  = 140;
	localparam int HOLD_CYCLES  = 200;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 4;
	localparam int GAP_PCT      = 8;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [7:0]  cfg_wdata = '0;
	logic        push      = 1'b0;
	logic [7:0]  char_in   = '0;
	logic        pop       = 1'b0;
	logic        full;
	logic        empty;
	logic        done_res;
	logic [31:0] number;
	logic        bad_char;
	logic        erase;

	int fail_count;
	int outstanding;
	int results_checked;
	int numbers_done;

	bit         gaps_on       = 1'b1;
	int         hold_req      = 0;
	int         chars_sent    = 0;
	int         settings_used = 1;
	logic [7:0] term_now      = NO_TERM;

	// Hand-picked opening sequence, run with no terminator
	logic [7:0] directed_chars [] = '{
		CH_SPACE, CH_ZERO, "x", "f", "F", "X", "g", CH_BS, CH_DEL,
		"1", "a", 8'hFF, CH_LF, CH_SPACE, CH_CR,
		8'h00, CH_CR,
		"9", "9", CH_BS, CH_BS,
		"7", 8'h00
	};

	// Terminator per phase; the last entry is replaced by a random one
	logic [7:0] term_values [] = '{8'hFF, ";", ",", "q", "A", "5", NO_TERM, 8'h00};

	ascii_number_parser uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.push     (push),
		.char_in  (char_in),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.done_res (done_res),
		.number   (number),
		.bad_char (bad_char),
		.erase    (erase)
	);

	anp_checker parse_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.push           (push),
		.char_in        (char_in),
		.full           (full),
		.pop            (pop),
		.empty          (empty),
		.done_res       (done_res),
		.number         (number),
		.bad_char       (bad_char),
		.erase          (erase),
		.fail_count     (fail_count),
		.outstanding    (outstanding),
		.results_checked(results_checked),
		.numbers_done   (numbers_done)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Offer one character, idling first at random, and hold it until transferred
	task automatic send_char(input logic [7:0] ch);
		while (gaps_on && $urandom_range(0, 99) < GAP_PCT) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push    <= 1'b1;
		char_in <= ch;
		@(posedge clk);
		while (full)
			@(posedge clk);
		chars_sent++;
	endtask

	// Stop offering and wait until every predicted result has been popped
	task automatic wait_for_results();
		push <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	task automatic set_terminator(input logic [7:0] value);
		wait_for_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we   <= 1'b0;
		term_now = value;
		settings_used++;
	endtask

	function automatic logic [7:0] pick_digit(input bit hex);
		int v;
		v = hex ? $urandom_range(0, 15) : $urandom_range(0, 9);
		if (v < 10)
			return CH_ZERO + 8'(v);
		return ($urandom_range(0, 1) ? CH_A : CH_LOW_A) + 8'(v - 10);
	endfunction

	// Characters that land in the bad-character path while collecting
	function automatic logic [7:0] odd_char();
		case ($urandom_range(0, 3))
			0: return CH_X;
			1: return 8'($urandom_range(8'h47, 8'h57));
			2: return 8'($urandom_range(8'h80, 8'hFE));
			default: return 8'($urandom_range(8'h21, 8'h2F));
		endcase
	endfunction

	// One number with random content, which may hold bad characters, sometimes left open
	task automatic send_number();
		bit hex;
		int r;
		repeat ($urandom_range(0, 2))
			send_char($urandom_range(0, 1) ? CH_SPACE : CH_ZERO);
		hex = $urandom_range(0, 1);
		if (hex)
			send_char($urandom_range(0, 1) ? CH_X : (CH_X | CASE_OFFSET));
		repeat ($urandom_range(1, 12)) begin
			r = $urandom_range(0, 99);
			if (r < 6)
				send_char(r < 3 ? CH_BS : CH_DEL);
			else if (r < 10)
				send_char(r < 8 ? CH_LF : CH_SPACE);
			else if (r < 14)
				send_char(odd_char());
			else
				send_char(pick_digit(hex));
		end
		r = $urandom_range(0, 9);
		if (r < 4)
			send_char(CH_CR);
		else if (r < 9)
			send_char(term_now);
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 4))
			send_char(8'($urandom_range(0, 255)));
	endtask

	// Receiver: pop with random gaps, or hold off for a long stretch on request
	initial begin
		int holds_done;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (hold_req != holds_done) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES)
					@(posedge clk);
				holds_done++;
			end else begin
				pop <= !(gaps_on && $urandom_range(0, 99) < GAP_PCT);
			end
		end
	end

	// Watchdog: end the run when no transfer happens for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				quiet = 0;
			else
				quiet++;
		end
		$display("no transfer for %0d cycles", IDLE_LIMIT);
		$display("ascii_number_parser: mismatch");
		$finish;
	end

	// Stimulus: reset, directed characters, then one random phase per terminator
	initial begin
		int  phase_end;
		bit  held;
		bit  paused;
		logic [7:0] next_term;
		held   = 1'b0;
		paused = 1'b0;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_chars[i])
			send_char(directed_chars[i]);

		foreach (term_values[p]) begin
			next_term = (p == term_values.size() - 1) ?
				8'($urandom_range(1, 255)) : term_values[p];
			set_terminator(next_term);
			// the second phase runs with no idling on either side
			gaps_on   = (p != 1);
			phase_end = chars_sent + PHASE_CHARS;
			while (chars_sent < phase_end) begin
				// stall the receiver while characters keep coming
				if (p == 3 && !held && chars_sent >= phase_end - 100) begin
					hold_req <= hold_req + 1;
					held = 1'b1;
				end
				// pause the sender until everything has drained
				if (p == 5 && !paused && chars_sent >= phase_end - 70) begin
					wait_for_results();
					paused = 1'b1;
				end
				if ($urandom_range(0, 99) < 85)
					send_number();
				else
					send_noise();
			end
		end

		wait_for_results();
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("covered %0d characters under %0d terminator settings: %0d results checked,",
			chars_sent, settings_used, results_checked);
		$display("%0d numbers completed, with a %0d-cycle receiver stall and a drained pause",
			numbers_done, HOLD_CYCLES);
		if (fail_count == 0 && outstanding == 0)
			$display("ascii_number_parser: match");
		else
			$display("ascii_number_parser: mismatch");
		$finish;
	end

endmodule
